### design/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and codes for the toggle stack: operation codes, result
// status codes and the control word broadcast along the cell row.
// ----------------------------------------------------------------------------
package dts_pkg;

  // default number of cells in the row
  localparam int STACK_DEPTH = 16;

  localparam int ValueW  = 8;
  localparam int StatusW = 3;
  localparam int DepthW  = 5;

  // operation carried in the input word's tuser
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_PUSHED  = 3'd0,
    ST_REMOVED = 3'd1,
    ST_POPPED  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  // control word seen by every cell in the same cycle
  typedef struct packed {
    logic              search;   // compare the value against the held entries
    logic              shift_en; // close the gap above a matching entry
    logic              load_en;  // write the value into the cell at the top
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

### design/dts_cell.sv
// ----------------------------------------------------------------------------
// dts_cell
// One slot of the stack. Compares its entry with the broadcast value,
// extends the match chain upward, takes its upper neighbor's entry when a
// match at or below it closes the gap, and offers its entry when on top.
// ----------------------------------------------------------------------------
module dts_cell #(
  parameter int STACK_DEPTH = dts_pkg::STACK_DEPTH,
  parameter int IDX         = 0,
  localparam int CW         = $clog2(STACK_DEPTH + 1)
) (
  input  logic                      clk_i,
  input  dts_pkg::cell_ctrl_t       ctrl_i,
  input  logic [CW-1:0]             count_i,
  input  logic [dts_pkg::ValueW-1:0] above_i,
  input  logic                      match_i,
  input  logic [dts_pkg::ValueW-1:0] top_i,
  output logic                      match_o,
  output logic [dts_pkg::ValueW-1:0] top_o,
  output logic [dts_pkg::ValueW-1:0] entry_o
);

  logic [dts_pkg::ValueW-1:0] entry_q, entry_d;
  logic                       valid;
  logic                       hit;

  // slot holds live data only below the fill count
  assign valid = count_i > CW'(IDX);
  assign hit   = ctrl_i.search && valid && (entry_q == ctrl_i.value);

  assign match_o = match_i | hit;
  assign top_o   = top_i | ((count_i == CW'(IDX + 1)) ? entry_q : '0);
  assign entry_o = entry_q;

  // shift down over a removed entry, or load a new top
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_en && match_o && valid) begin
      entry_d = above_i;
    end else if (ctrl_i.load_en && (count_i == CW'(IDX))) begin
      entry_d = ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### design/dedup_toggle_stack.sv
// ----------------------------------------------------------------------------
// dedup_toggle_stack
// Byte stack acting as an ordered set: a push of a held value removes it,
// a push of a new value stacks it unless full, a pop returns the top entry.
// ----------------------------------------------------------------------------
// Result: registered; the result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while the result stream is not stalled; the row of
//   cells compares, ripples the match chain and shifts combinationally.
// Reset: clears the fill count and the output valid; entries need no clear.
// ----------------------------------------------------------------------------
module dedup_toggle_stack #(
  parameter int STACK_DEPTH = dts_pkg::STACK_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] value
  input  logic [0:0]  s_axis_tuser,  // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] popped_value, [12:8] depth, rest zero
  output logic [2:0]  m_axis_tuser   // [2:0] status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic          accept;
  logic          push;
  logic          found;
  logic          full;

  logic                        out_valid_q;
  logic [dts_pkg::ValueW-1:0]  popped_q, popped_d;
  dts_pkg::status_e            status_q, status_d;
  logic [dts_pkg::DepthW-1:0]  depth_q;
  logic [CW+dts_pkg::DepthW-1:0] depth_ext;

  dts_pkg::cell_ctrl_t         ctrl;
  logic [STACK_DEPTH:0]        match_c;
  logic [dts_pkg::ValueW-1:0]  top_c   [STACK_DEPTH+1];
  logic [dts_pkg::ValueW-1:0]  entry_c [STACK_DEPTH];
  logic [dts_pkg::ValueW-1:0]  above_c [STACK_DEPTH];

  // handshake: output register frees up when taken
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = (s_axis_tuser[0] == dts_pkg::MODE_PUSH);
  assign full          = (count_q == CW'(STACK_DEPTH));
  assign found         = match_c[STACK_DEPTH];

  // broadcast to the row
  assign ctrl.search   = push;
  assign ctrl.shift_en = accept && push;
  assign ctrl.load_en  = accept && push && !found && !full;
  assign ctrl.value    = s_axis_tdata;

  assign match_c[0] = 1'b0;
  assign top_c[0]   = '0;

  // row of cells, match and top chains running upward
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == STACK_DEPTH - 1) begin : g_last
      assign above_c[i] = '0;
    end else begin : g_mid
      assign above_c[i] = entry_c[i+1];
    end

    dts_cell #(
      .STACK_DEPTH (STACK_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .above_i (above_c[i]),
      .match_i (match_c[i]),
      .top_i   (top_c[i]),
      .match_o (match_c[i+1]),
      .top_o   (top_c[i+1]),
      .entry_o (entry_c[i])
    );
  end

  // result and next fill count
  always_comb begin
    count_d  = count_q;
    popped_d = '0;
    status_d = dts_pkg::ST_PUSHED;
    if (!push) begin
      if (count_q == '0) begin
        status_d = dts_pkg::ST_EMPTY;
      end else begin
        status_d = dts_pkg::ST_POPPED;
        popped_d = top_c[STACK_DEPTH];
        count_d  = count_q - CW'(1);
      end
    end else if (found) begin
      status_d = dts_pkg::ST_REMOVED;
      count_d  = count_q - CW'(1);
    end else if (full) begin
      status_d = dts_pkg::ST_FULL;
    end else begin
      status_d = dts_pkg::ST_PUSHED;
      count_d  = count_q + CW'(1);
    end
  end

  assign depth_ext = {{dts_pkg::DepthW{1'b0}}, count_d};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
      depth_q  <= depth_ext[dts_pkg::DepthW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, depth_q, popped_q};
  assign m_axis_tuser  = status_q;

endmodule

### design/dts_checker.sv
// ----------------------------------------------------------------------------
// dts_checker
// Port-level checks on the toggle stack's result stream, bound to the
// top level.
// ----------------------------------------------------------------------------
module dts_checker #(
  parameter int STACK_DEPTH = dts_pkg::STACK_DEPTH
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  localparam logic [4:0] FullDepth = 5'(STACK_DEPTH % 32);

  // every accepted word gives a result word in the next cycle
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result word after an accepted input word");

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // only a pop carries data
  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != dts_pkg::ST_POPPED) |-> m_axis_tdata[7:0] == 8'd0)
    else $error("nonzero popped value on a non-pop result");

  // empty report means no entries
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == dts_pkg::ST_EMPTY) |-> m_axis_tdata[12:8] == 5'd0)
    else $error("empty status with nonzero depth");

  // full report means every slot taken
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == dts_pkg::ST_FULL) |-> m_axis_tdata[12:8] == FullDepth)
    else $error("full status with depth below capacity");

endmodule

bind dedup_toggle_stack dts_checker #(.STACK_DEPTH(STACK_DEPTH)) u_dts_checker (.*);

### sim/dedup_toggle_stack_tb.sv
// ----------------------------------------------------------------------------
// dedup_toggle_stack_tb
// Self-checking bench for the toggle stack. A queue of push and pop words
// feeds a clocked driver; every accepted input word runs through a local
// copy of the stack, and the expected status, popped byte and depth are
// queued. A clocked monitor checks each result word against the oldest
// expectation. Directed words hit empty, full and mid-stack removal, then
// random bursts fill, churn and drain the stack under varying back-pressure.
// ----------------------------------------------------------------------------
module dedup_toggle_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 80;
  localparam int StallLimit = 1000;

  typedef struct {
    logic                       mode;
    logic [dts_pkg::ValueW-1:0] value;
  } op_t;

  typedef struct {
    logic [dts_pkg::ValueW-1:0] popped;
    dts_pkg::status_e           status;
    logic [dts_pkg::DepthW-1:0] depth;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  op_t      ops_todo [$];
  outcome_t outcomes_due [$];

  // local copy of the stack contents
  logic [dts_pkg::ValueW-1:0] held [dts_pkg::STACK_DEPTH];
  int                         held_cnt  = 0;

  int words_in  = 0;
  int words_out = 0;
  int hold_left = 0;
  int idle_run  = 0;
  int errs      = 0;

  dedup_toggle_stack DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] value
    .s_axis_tuser  (s_axis_tuser),   // [0] mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] popped_value, [12:8] depth
    .m_axis_tuser  (m_axis_tuser)    // [2:0] status
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // apply one operation to the local stack and return the result it gives
  function automatic outcome_t apply_op(op_t op);
    outcome_t r;
    int       hit;
    r.popped = '0;
    r.status = dts_pkg::ST_PUSHED;
    hit      = -1;
    if (op.mode == dts_pkg::MODE_POP) begin
      if (held_cnt == 0) begin
        r.status = dts_pkg::ST_EMPTY;
      end else begin
        held_cnt--;
        r.popped = held[held_cnt];
        r.status = dts_pkg::ST_POPPED;
      end
    end else begin
      for (int i = 0; i < held_cnt; i++)
        if (hit < 0 && held[i] == op.value) hit = i;
      if (hit >= 0) begin
        // close the gap left by the matching entry
        for (int j = hit; j < held_cnt - 1; j++) held[j] = held[j + 1];
        held_cnt--;
        r.status = dts_pkg::ST_REMOVED;
      end else if (held_cnt >= dts_pkg::STACK_DEPTH) begin
        r.status = dts_pkg::ST_FULL;
      end else begin
        held[held_cnt] = op.value;
        held_cnt++;
      end
    end
    r.depth = dts_pkg::DepthW'(held_cnt);
    return r;
  endfunction

  // idle percentage per side: sender light / receiver heavy, then swapped,
  // then no idling at all
  function automatic int idle_pct(bit rx_side);
    if (words_in < 220) return rx_side ? 72 : 12;
    if (words_in < 440) return rx_side ? 12 : 72;
    return 0;
  endfunction

  task automatic report(string what, int got, int want);
    errs++;
    $display("ERROR %s: got %0h expected %0h (result word %0d)", what, got, want, words_out);
  endtask

  task automatic add_op(logic mode, logic [dts_pkg::ValueW-1:0] value);
    op_t op;
    op.mode  = mode;
    op.value = value;
    ops_todo.push_back(op);
  endtask

  // random bursts: fill (mostly fresh pushes), churn (small value pool so
  // pushes often hit held entries) and drain (mostly pops)
  task automatic add_random(int n);
    logic [dts_pkg::ValueW-1:0] pool [8];
    int                         kind;
    int                         pop_pct;
    int                         left;
    left    = 0;
    kind    = 0;
    pop_pct = 0;
    for (int k = 0; k < n; k++) begin
      if (left == 0) begin
        kind    = $urandom_range(0, 2);
        left    = $urandom_range(10, 40);
        pop_pct = (kind == 0) ? 5 : (kind == 1) ? 25 : 65;
        foreach (pool[p]) pool[p] = 8'($urandom);
      end
      left--;
      if (kind == 0 || $urandom_range(0, 3) == 0)
        add_op(($urandom_range(0, 99) < pop_pct) ? dts_pkg::MODE_POP : dts_pkg::MODE_PUSH,
               8'($urandom));
      else
        add_op(($urandom_range(0, 99) < pop_pct) ? dts_pkg::MODE_POP : dts_pkg::MODE_PUSH,
               pool[$urandom_range(0, 7)]);
    end
  endtask

  // sender holds off until every issued word has its result back
  task automatic wait_drained();
    @(negedge clk_i);
    while (ops_todo.size() != 0 || s_axis_tvalid || outcomes_due.size() != 0)
      @(negedge clk_i);
  endtask

  // driver: offers queued words, predicts each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    op_t acc;
    op_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.mode  = s_axis_tuser[0];
        acc.value = s_axis_tdata;
        outcomes_due.push_back(apply_op(acc));
        words_in <= words_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ops_todo.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          nxt = ops_todo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.value;
          s_axis_tuser  <= nxt.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random ready, two long hold-offs, field checks
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_out <= words_out + 1;
        if (outcomes_due.size() == 0) begin
          report("result word with nothing pending", m_axis_tdata, 0);
        end else begin
          want = outcomes_due.pop_front();
          if (m_axis_tdata[7:0] !== want.popped)
            report("popped_value", m_axis_tdata[7:0], want.popped);
          if (m_axis_tdata[12:8] !== want.depth)
            report("depth", m_axis_tdata[12:8], want.depth);
          if (m_axis_tdata[15:13] !== 3'b000)
            report("tdata padding", m_axis_tdata[15:13], 0);
          if (m_axis_tuser !== want.status)
            report("status", m_axis_tuser, want.status);
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (m_axis_tvalid && m_axis_tready && (words_out == 50 || words_out == 500)) begin
        // long stall so the block backs up and drops s_axis_tready
        m_axis_tready <= 1'b0;
        hold_left     <= HoldCycles;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_run <= 0;
      else
        idle_run <= idle_run + 1;
      if (idle_run >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    // directed: empty pop, byte extremes, bottom removal, fill to full,
    // full push, removal while full, refill, pop of the top
    add_op(dts_pkg::MODE_POP,  8'hA5);
    add_op(dts_pkg::MODE_PUSH, 8'h00);
    add_op(dts_pkg::MODE_PUSH, 8'hFF);
    add_op(dts_pkg::MODE_PUSH, 8'h00);
    add_op(dts_pkg::MODE_POP,  8'h00);
    add_op(dts_pkg::MODE_POP,  8'h5A);
    for (int v = 1; v <= dts_pkg::STACK_DEPTH; v++) add_op(dts_pkg::MODE_PUSH, 8'(v * 15));
    add_op(dts_pkg::MODE_PUSH, 8'h01);
    add_op(dts_pkg::MODE_PUSH, 8'd120);
    add_op(dts_pkg::MODE_PUSH, 8'h01);
    add_op(dts_pkg::MODE_POP,  8'hFF);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();
    add_random(300);
    wait_drained();
    add_random(350);
    wait_drained();
    repeat (4) @(posedge clk_i);

    if (outcomes_due.size() != 0)
      report("results never returned", outcomes_due.size(), 0);
    if (errs == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
